[hdl/mec_pkg.sv]
// shared types and constants for the mandelbrot escape counter
package mec_pkg;

  localparam int FRAC_BITS = 58;
  localparam int WORD_W    = 64;
  localparam int WIDE_W    = 2 * WORD_W;
  // |z|^2 >= 4 in the squared format means a bit at or above this position is set
  localparam int ESC_BIT   = 2 * FRAC_BITS + 2;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 7;
  localparam int COUNT_W = 8;
  localparam int INDEX_W = 3;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd255;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_START_RE   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_START_IM   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_STEP_RE    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_STEP_IM    = 3'd3;
  localparam logic [INDEX_W-1:0] REG_ITER_LIMIT = 3'd4;

  // partial products of a 64x64 multiply, issued in this order
  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_LH = 2'd1;
  localparam logic [1:0] PP_HL = 2'd2;
  localparam logic [1:0] PP_HH = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOOP,
    ST_WAIT_RR,
    ST_WAIT_II,
    ST_CHECK,
    ST_WAIT_X,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] prod;
  } mul_rsp_t;

endpackage

[hdl/mec_if.sv]
// channel interfaces for pixel input, result output and configuration writes
interface mec_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [mec_pkg::COL_W-1:0]   col;
  logic [mec_pkg::ROW_W-1:0]   row;
  modport source (output valid, output col, output row, input ready);
  modport sink (input valid, input col, input row, output ready);
endinterface

interface mec_result_if;
  logic                        valid;
  logic                        ready;
  logic [mec_pkg::COUNT_W-1:0] iter_count;
  logic [mec_pkg::COL_W-1:0]   out_col;
  logic [mec_pkg::ROW_W-1:0]   out_row;
  modport source (output valid, output iter_count, output out_col, output out_row,
                  input ready);
  modport sink (input valid, input iter_count, input out_col, input out_row,
                output ready);
endinterface

interface mec_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mec_pkg::INDEX_W-1:0] index;
  logic [mec_pkg::WORD_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/mec_mul.sv]
// shared signed 64x64 multiplier built from four 33x33 partial products
module mec_mul (
  input  logic              clk,
  input  logic              rst,
  input  mec_pkg::mul_req_t req,
  output mec_pkg::mul_rsp_t rsp
);

  logic [mec_pkg::WORD_W-1:0] a_r;
  logic [mec_pkg::WORD_W-1:0] b_r;
  logic [1:0]                 cnt;
  logic                       issuing;
  logic signed [65:0]         prod_r;
  logic [1:0]                 psh;
  logic                       pvalid;
  logic                       plast;
  logic [mec_pkg::WIDE_W-1:0] acc;
  logic                       done;

  logic signed [32:0]         op_a;
  logic signed [32:0]         op_b;
  logic [mec_pkg::WIDE_W-1:0] ext;
  logic [mec_pkg::WIDE_W-1:0] addend;

  // low halves are unsigned, high halves carry the sign
  always_comb begin
    case (cnt)
      mec_pkg::PP_LL: begin
        op_a = {1'b0, a_r[31:0]};
        op_b = {1'b0, b_r[31:0]};
      end
      mec_pkg::PP_LH: begin
        op_a = {1'b0, a_r[31:0]};
        op_b = {b_r[63], b_r[63:32]};
      end
      mec_pkg::PP_HL: begin
        op_a = {a_r[63], a_r[63:32]};
        op_b = {1'b0, b_r[31:0]};
      end
      default: begin
        op_a = {a_r[63], a_r[63:32]};
        op_b = {b_r[63], b_r[63:32]};
      end
    endcase
  end

  assign ext = {{(mec_pkg::WIDE_W-66){prod_r[65]}}, prod_r};

  always_comb begin
    case (psh)
      mec_pkg::PP_LL: addend = ext;
      mec_pkg::PP_LH: addend = ext << 32;
      mec_pkg::PP_HL: addend = ext << 32;
      default:        addend = ext << 64;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      pvalid  <= 1'b0;
      plast   <= 1'b0;
      done    <= 1'b0;
      cnt     <= mec_pkg::PP_LL;
    end else begin
      done   <= pvalid && plast;
      pvalid <= issuing;
      plast  <= issuing && (cnt == mec_pkg::PP_HH);
      if (req.start) begin
        issuing <= 1'b1;
        cnt     <= mec_pkg::PP_LL;
      end else if (issuing) begin
        cnt <= cnt + 2'd1;
        if (cnt == mec_pkg::PP_HH) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    prod_r <= op_a * op_b;
    psh    <= cnt;
    if (req.start) begin
      acc <= '0;
    end else if (pvalid) begin
      acc <= acc + addend;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

  a_start: assert property (@(posedge clk) disable iff (rst)
    req.start |=> issuing && (cnt == mec_pkg::PP_LL))
    else $error("multiplier did not begin issuing after start");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("multiplier done held for more than one cycle");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !issuing)
    else $error("multiplier started while still issuing");

endmodule

[hdl/mandelbrot_escape_counter.sv]
// escape-time counter: one pixel at a time through a shared multiplier
// each iteration issues three multiplies (re*re, im*im, re*im) in turn on the shared multiplier,
// with one loop test and one magnitude check; an escaping pixel stops at the check, before re*im
// a new pixel is taken only after the last one is done; the next pixel is taken while a result waits
// reset: synchronous rst clears the sequencer and output valid, starts and steps
// go to zero and the iteration limit to 255
module mandelbrot_escape_counter (
  input  logic         clk,
  input  logic         rst,
  mec_cfg_if.sink      cfg,
  mec_pixel_if.sink    pixel,
  mec_result_if.source result
);

  mec_pkg::state_t state;
  mec_pkg::state_t state_next;

  logic [mec_pkg::WORD_W-1:0]  start_re;
  logic [mec_pkg::WORD_W-1:0]  start_im;
  logic [mec_pkg::WORD_W-1:0]  step_re;
  logic [mec_pkg::WORD_W-1:0]  step_im;
  logic [mec_pkg::COUNT_W-1:0] iter_limit;

  logic [mec_pkg::COL_W-1:0]   col_r;
  logic [mec_pkg::ROW_W-1:0]   row_r;
  logic [mec_pkg::WORD_W-1:0]  cr;
  logic [mec_pkg::WORD_W-1:0]  ci;
  logic [mec_pkg::WORD_W-1:0]  zr;
  logic [mec_pkg::WORD_W-1:0]  zi;
  logic [mec_pkg::WIDE_W-1:0]  r2;
  logic [mec_pkg::WIDE_W-1:0]  i2;
  logic [mec_pkg::WORD_W-1:0]  dif_sh;
  logic [mec_pkg::COUNT_W-1:0] n;

  logic                        res_valid;
  logic [mec_pkg::COUNT_W-1:0] res_count;
  logic [mec_pkg::COL_W-1:0]   res_col;
  logic [mec_pkg::ROW_W-1:0]   res_row;

  mec_pkg::mul_req_t mul_req;
  mec_pkg::mul_rsp_t mul_rsp;

  logic [mec_pkg::WIDE_W-1:0] mag;
  logic [mec_pkg::WIDE_W-1:0] dif;
  logic                       escaped;
  logic                       out_free;
  logic                       pix_take;
  logic                       load_out;

  mec_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign mag      = r2 + i2;
  assign dif      = r2 - i2;
  assign escaped  = |mag[mec_pkg::WIDE_W-1:mec_pkg::ESC_BIT];
  assign out_free = !res_valid || result.ready;
  assign pix_take = pixel.valid && pixel.ready;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_re   <= '0;
      start_im   <= '0;
      step_re    <= '0;
      step_im    <= '0;
      iter_limit <= mec_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        mec_pkg::REG_START_RE:   start_re   <= cfg.data;
        mec_pkg::REG_START_IM:   start_im   <= cfg.data;
        mec_pkg::REG_STEP_RE:    step_re    <= cfg.data;
        mec_pkg::REG_STEP_IM:    step_im    <= cfg.data;
        mec_pkg::REG_ITER_LIMIT: iter_limit <= cfg.data[mec_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mec_pkg::ST_IDLE:    if (pixel.valid) state_next = mec_pkg::ST_SETUP;
      mec_pkg::ST_SETUP:   state_next = mec_pkg::ST_LOOP;
      mec_pkg::ST_LOOP: begin
        if (n >= iter_limit) state_next = mec_pkg::ST_DONE;
        else state_next = mec_pkg::ST_WAIT_RR;
      end
      mec_pkg::ST_WAIT_RR: if (mul_rsp.done) state_next = mec_pkg::ST_WAIT_II;
      mec_pkg::ST_WAIT_II: if (mul_rsp.done) state_next = mec_pkg::ST_CHECK;
      mec_pkg::ST_CHECK: begin
        if (escaped) state_next = mec_pkg::ST_DONE;
        else state_next = mec_pkg::ST_WAIT_X;
      end
      mec_pkg::ST_WAIT_X:  if (mul_rsp.done) state_next = mec_pkg::ST_LOOP;
      mec_pkg::ST_DONE:    if (out_free) state_next = mec_pkg::ST_IDLE;
      default:             state_next = mec_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = zr;
    mul_req.b     = zr;
    pixel.ready   = 1'b0;
    load_out      = 1'b0;
    case (state)
      mec_pkg::ST_IDLE: pixel.ready = 1'b1;
      mec_pkg::ST_LOOP: mul_req.start = (n < iter_limit);
      mec_pkg::ST_WAIT_RR: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = zi;
        mul_req.b     = zi;
      end
      mec_pkg::ST_CHECK: begin
        mul_req.start = !escaped;
        mul_req.a     = zr;
        mul_req.b     = zi;
      end
      mec_pkg::ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mec_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pix_take) begin
      col_r <= pixel.col;
      row_r <= pixel.row;
    end
    case (state)
      mec_pkg::ST_SETUP: begin
        cr <= start_re + step_re * {{(mec_pkg::WORD_W-mec_pkg::COL_W){1'b0}}, col_r};
        ci <= start_im + step_im * {{(mec_pkg::WORD_W-mec_pkg::ROW_W){1'b0}}, row_r};
        zr <= start_re + step_re * {{(mec_pkg::WORD_W-mec_pkg::COL_W){1'b0}}, col_r};
        zi <= start_im + step_im * {{(mec_pkg::WORD_W-mec_pkg::ROW_W){1'b0}}, row_r};
        n  <= '0;
      end
      mec_pkg::ST_WAIT_RR: if (mul_rsp.done) r2 <= mul_rsp.prod;
      mec_pkg::ST_WAIT_II: if (mul_rsp.done) i2 <= mul_rsp.prod;
      mec_pkg::ST_CHECK:
        dif_sh <= dif[mec_pkg::FRAC_BITS+mec_pkg::WORD_W-1:mec_pkg::FRAC_BITS];
      mec_pkg::ST_WAIT_X: begin
        if (mul_rsp.done) begin
          // 2*re*im >> F taken as re*im >> (F-1)
          zr <= dif_sh + cr;
          zi <= mul_rsp.prod[mec_pkg::FRAC_BITS+mec_pkg::WORD_W-2:mec_pkg::FRAC_BITS-1] + ci;
          n  <= n + 8'd1;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      res_count <= n;
      res_col   <= col_r;
      res_row   <= row_r;
    end
  end

  assign result.valid      = res_valid;
  assign result.iter_count = res_count;
  assign result.out_col    = res_col;
  assign result.out_row    = res_row;

  a_take_setup: assert property (@(posedge clk) disable iff (rst)
    pix_take |=> state == mec_pkg::ST_SETUP)
    else $error("accepted pixel did not enter setup");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == mec_pkg::ST_WAIT_RR || state == mec_pkg::ST_WAIT_II ||
                      state == mec_pkg::ST_WAIT_X))
    else $error("multiplier finished with no product expected");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == mec_pkg::ST_DONE |-> n <= iter_limit)
    else $error("iteration count passed the limit");

endmodule
